>>> design/rksa_pkg.sv
// ----------------------------------------------------------------------------
// rksa_pkg
// Shared types, codes and constants of the reference-counted key slot
// allocator.
// ----------------------------------------------------------------------------
package rksa_pkg;

    // Default sizes
    localparam int DEF_KEY_ENTRIES = 64;
    localparam int DEF_SLOT_COUNT  = 256;

    // Field widths
    localparam int OP_W       = 2;
    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 16;
    localparam int SLOT_W     = 9;
    localparam int FIRST_W    = 8;
    localparam int LIMIT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Operation codes (code three acts as a query)
    localparam logic [OP_W-1:0] OP_JOIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEAVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LIMIT = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [SLOT_W-1:0]  NO_SLOT   = 9'h1FF;

    // One key table entry as stored in memory
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot;
    } entry_t;

    // Outcome of one key table scan
    typedef struct packed {
        logic   hit;
        logic   free_found;
        entry_t entry;
    } scan_res_t;

    // Commands to the free stack
    typedef struct packed {
        logic               reload;
        logic [FIRST_W-1:0] first;
        logic [LIMIT_W-1:0] limit;
        logic               pop;
        logic               push;
        logic [SLOT_W-1:0]  push_slot;
    } stk_cmd_t;

    // Free stack status
    typedef struct packed {
        logic              top_valid;
        logic [SLOT_W-1:0] top_slot;
    } stk_stat_t;

endpackage

>>> design/rksa_ram.sv
// ----------------------------------------------------------------------------
// rksa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rksa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/rksa_key_table.sv
// ----------------------------------------------------------------------------
// rksa_key_table
// Key table memory with a clearing pass after reset and a linear scan that
// finds the entry of a key and the lowest free entry.
// ----------------------------------------------------------------------------
module rksa_key_table
    import rksa_pkg::*;
#(
    parameter int KEY_ENTRIES = DEF_KEY_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    input  logic                           wr_en,
    input  logic [$clog2(KEY_ENTRIES)-1:0] wr_addr,
    input  entry_t                         wr_data,
    output logic                           clear_busy,
    output logic                           done,
    output scan_res_t                      res,
    output logic [$clog2(KEY_ENTRIES)-1:0] hit_idx,
    output logic [$clog2(KEY_ENTRIES)-1:0] free_idx
);

    localparam int EIDX_W = $clog2(KEY_ENTRIES);
    localparam logic [EIDX_W-1:0] LAST = EIDX_W'(KEY_ENTRIES - 1);

    logic              clr_active_reg, clr_active_next;
    logic [EIDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              scan_active_reg, scan_active_next;
    logic [EIDX_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [EIDX_W-1:0] cmp_addr_reg, cmp_addr_next;
    logic              done_reg, done_next;
    scan_res_t         res_reg, res_next;
    logic [EIDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [EIDX_W-1:0] free_idx_reg, free_idx_next;

    logic              ram_we;
    logic [EIDX_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    // clearing pass owns the write port after reset
    assign ram_we    = clr_active_reg | wr_en;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : wr_addr;
    assign ram_wdata = clr_active_reg ? entry_t'('0) : wr_data;

    rksa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (KEY_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        clr_active_next  = clr_active_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_active_next = scan_active_reg;
        issue_cnt_next   = issue_cnt_reg;
        cmp_valid_next   = 1'b0;
        cmp_addr_next    = issue_cnt_reg;
        done_next        = 1'b0;
        res_next         = res_reg;
        hit_idx_next     = hit_idx_reg;
        free_idx_next    = free_idx_reg;

        if (clr_active_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST) begin
                clr_active_next = 1'b0;
            end
        end

        // issue stage
        if (start) begin
            scan_active_next = 1'b1;
            issue_cnt_next   = '0;
            res_next         = '0;
        end else if (scan_active_reg) begin
            cmp_valid_next = 1'b1;
            if (issue_cnt_reg == LAST) begin
                scan_active_next = 1'b0;
            end else begin
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
        end

        // compare stage, read data lines up with cmp_valid_reg
        if (cmp_valid_reg) begin
            if (ram_rdata.valid && ram_rdata.key == key && !res_reg.hit) begin
                res_next.hit   = 1'b1;
                res_next.entry = ram_rdata;
                hit_idx_next   = cmp_addr_reg;
            end
            if (!ram_rdata.valid && !res_reg.free_found) begin
                res_next.free_found = 1'b1;
                free_idx_next       = cmp_addr_reg;
            end
            done_next = (cmp_addr_reg == LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg  <= 1'b1;
            clr_cnt_reg     <= '0;
            scan_active_reg <= 1'b0;
            issue_cnt_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end else begin
            clr_active_reg  <= clr_active_next;
            clr_cnt_reg     <= clr_cnt_next;
            scan_active_reg <= scan_active_next;
            issue_cnt_reg   <= issue_cnt_next;
            cmp_valid_reg   <= cmp_valid_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_addr_reg <= cmp_addr_next;
        res_reg      <= res_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign clear_busy = clr_active_reg;
    assign done       = done_reg;
    assign res        = res_reg;
    assign hit_idx    = hit_idx_reg;
    assign free_idx   = free_idx_reg;

endmodule

>>> design/rksa_free_stack.sv
// ----------------------------------------------------------------------------
// rksa_free_stack
// LIFO of free slot indexes in memory. A reload marks the bottom entries as
// holding first + i without touching the memory; pushes lower that mark.
// ----------------------------------------------------------------------------
module rksa_free_stack
    import rksa_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  stk_cmd_t  cmd,
    output stk_stat_t stat
);

    localparam int DEPTH_W = $clog2(SLOT_COUNT + 1);
    localparam int SAW     = $clog2(SLOT_COUNT);
    localparam int CW      = (DEPTH_W > SLOT_W) ? DEPTH_W : SLOT_W;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] pristine_reg, pristine_next;
    logic [FIRST_W-1:0] first_reg;

    logic [DEPTH_W-1:0] top_idx;
    logic [SLOT_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [CW-1:0]      lim;
    logic [CW-1:0]      fill;
    logic               not_full;

    assign top_idx  = depth_reg - 1'b1;
    assign not_full = depth_reg < DEPTH_W'(SLOT_COUNT);
    assign ram_we   = cmd.push && not_full;

    rksa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (depth_reg[SAW-1:0]),
        .wdata (cmd.push_slot),
        .raddr (top_idx[SAW-1:0]),
        .rdata (ram_rdata)
    );

    // reload size: slots first .. min(limit, SLOT_COUNT) - 1
    always_comb begin
        if (CW'(cmd.limit) > CW'(SLOT_COUNT)) begin
            lim = CW'(SLOT_COUNT);
        end else begin
            lim = CW'(cmd.limit);
        end
        if (lim > CW'(cmd.first)) begin
            fill = lim - CW'(cmd.first);
        end else begin
            fill = '0;
        end
    end

    always_comb begin
        depth_next    = depth_reg;
        pristine_next = pristine_reg;
        if (cmd.reload) begin
            depth_next    = DEPTH_W'(fill);
            pristine_next = DEPTH_W'(fill);
        end else if (cmd.pop) begin
            depth_next = top_idx;
        end else if (ram_we) begin
            depth_next = depth_reg + 1'b1;
            if (depth_reg < pristine_reg) begin
                pristine_next = depth_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            pristine_reg <= '0;
        end else begin
            depth_reg    <= depth_next;
            pristine_reg <= pristine_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.reload) begin
            first_reg <= cmd.first;
        end
    end

    assign stat.top_valid = depth_reg != '0;
    assign stat.top_slot  = (top_idx < pristine_reg)
                          ? SLOT_W'(CW'(first_reg) + CW'(top_idx))
                          : ram_rdata;

endmodule

>>> design/refcounted_key_slot_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_key_slot_allocator
// Reference-counted key table that binds slots from a LIFO free stack.
// One item at a time: a new item is taken only after the previous one has been
//   committed to the output register, and the commit waits while that register
//   is held; the key table scan reads one entry per cycle through the single
//   read port of its memory.
// Reset: a clearing pass invalidates the key table; s_ready stays low until it
//   ends. Registers and the free stack start empty.
// ----------------------------------------------------------------------------
module refcounted_key_slot_allocator
    import rksa_pkg::*;
#(
    parameter int KEY_ENTRIES = DEF_KEY_ENTRIES,
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic [KEY_W-1:0]        s_group_key,
    // result items
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COUNT_W-1:0]      m_member_count,
    output logic signed [SLOT_W-1:0] m_slot_index,
    output logic                    m_table_full
);

    localparam int EIDX_W = $clog2(KEY_ENTRIES);

    // Sequencer states: wait for an item, scan the key table, then commit
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_SCAN   = 2'd1;
    localparam logic [ST_W-1:0] ST_DECIDE = 2'd2;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;

    logic               enabled_reg;
    logic [FIRST_W-1:0] area_first_reg;
    logic [LIMIT_W-1:0] area_limit_reg;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic               m_full_reg;

    logic               s_accept;
    logic               cfg_wr;
    logic               out_free;
    logic               commit;

    // key table side
    logic               clear_busy;
    logic               scan_done;
    scan_res_t          scan;
    logic [EIDX_W-1:0]  hit_idx;
    logic [EIDX_W-1:0]  free_idx;
    logic               tbl_we;
    logic [EIDX_W-1:0]  tbl_waddr;
    entry_t             tbl_wdata;

    // free stack side
    stk_cmd_t           stk_cmd;
    stk_stat_t          stk_stat;
    logic               want_pop;
    logic               want_push;

    // decided result
    logic [COUNT_W-1:0] res_count;
    logic [SLOT_W-1:0]  res_slot;
    logic               res_full;
    logic               want_we;

    // ------------------------------------------------------------------
    // Handshakes. One item at a time; the next one is taken while the
    // previous result still sits in the output register.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !clear_busy;
    assign s_accept  = s_valid & s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    // the decide state is left only when the result can be handed to the output register
    assign commit    = (state_reg == ST_DECIDE) && out_free;

    // ------------------------------------------------------------------
    // Configuration registers. A write of the range registers reloads the
    // free stack with the new range in the same cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b0;
            area_first_reg <= '0;
            area_limit_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_ENABLED:    enabled_reg    <= cfg_data[0];
                REG_AREA_FIRST: area_first_reg <= cfg_data[FIRST_W-1:0];
                REG_AREA_LIMIT: area_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_operation;
            key_reg <= s_group_key;
        end
    end

    // ------------------------------------------------------------------
    // Key table: linear scan for the key and the lowest free entry
    // ------------------------------------------------------------------
    rksa_key_table #(
        .KEY_ENTRIES (KEY_ENTRIES)
    ) u_key_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_accept),
        .key        (key_reg),
        .wr_en      (tbl_we),
        .wr_addr    (tbl_waddr),
        .wr_data    (tbl_wdata),
        .clear_busy (clear_busy),
        .done       (scan_done),
        .res        (scan),
        .hit_idx    (hit_idx),
        .free_idx   (free_idx)
    );

    // ------------------------------------------------------------------
    // Decide: read-modify-write of one entry plus at most one stack pop or
    // push. Disabled or query items (and op code three) only report.
    // ------------------------------------------------------------------
    always_comb begin
        res_count = scan.hit ? scan.entry.count : '0;
        res_slot  = scan.hit ? scan.entry.slot : NO_SLOT;
        res_full  = 1'b0;
        want_we   = 1'b0;
        want_pop  = 1'b0;
        want_push = 1'b0;
        tbl_waddr = hit_idx;
        tbl_wdata = scan.entry;

        if (enabled_reg && op_reg == OP_JOIN) begin
            if (scan.hit) begin
                // saturating count
                if (scan.entry.count != COUNT_MAX) begin
                    want_we         = 1'b1;
                    tbl_wdata.count = scan.entry.count + 1'b1;
                    res_count       = tbl_wdata.count;
                end
            end else if (scan.free_found) begin
                // new key: claim the free entry and pop a slot if any
                want_we         = 1'b1;
                want_pop        = stk_stat.top_valid;
                tbl_waddr       = free_idx;
                tbl_wdata.valid = 1'b1;
                tbl_wdata.key   = key_reg;
                tbl_wdata.count = COUNT_W'(1);
                tbl_wdata.slot  = stk_stat.top_valid ? stk_stat.top_slot : NO_SLOT;
                res_count       = tbl_wdata.count;
                res_slot        = tbl_wdata.slot;
            end else begin
                // table full: dropped
                res_full = 1'b1;
            end
        end else if (enabled_reg && op_reg == OP_LEAVE && scan.hit) begin
            want_we         = 1'b1;
            tbl_wdata.count = scan.entry.count - 1'b1;
            res_count       = tbl_wdata.count;
            if (tbl_wdata.count == '0) begin
                // last member gone: free the entry, return its slot
                tbl_wdata.valid = 1'b0;
                want_push       = scan.entry.slot != NO_SLOT;
                res_slot        = NO_SLOT;
            end
        end
    end

    assign tbl_we = commit && want_we;

    // ------------------------------------------------------------------
    // Free stack
    // ------------------------------------------------------------------
    always_comb begin
        stk_cmd.reload    = cfg_wr && (cfg_index == REG_AREA_FIRST ||
                                       cfg_index == REG_AREA_LIMIT);
        stk_cmd.first     = (cfg_index == REG_AREA_FIRST) ? cfg_data[FIRST_W-1:0]
                                                          : area_first_reg;
        stk_cmd.limit     = (cfg_index == REG_AREA_LIMIT) ? cfg_data[LIMIT_W-1:0]
                                                          : area_limit_reg;
        stk_cmd.pop       = commit && want_pop;
        stk_cmd.push      = commit && want_push;
        stk_cmd.push_slot = scan.entry.slot;
    end

    rksa_free_stack #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_free_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_count_reg <= res_count;
            m_slot_reg  <= res_slot;
            m_full_reg  <= res_full;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_member_count = m_count_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_table_full   = m_full_reg;

endmodule

>>> verif/refcounted_key_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// refcounted_key_slot_allocator_tb
// Self-checking bench for the reference-counted key slot allocator. A local
// copy of the key table and free stack predicts count, slot and table-full for
// every accepted item. Results are compared in order against that prediction.
// A short directed part is followed by random phases over reshaped slot ranges.
// ----------------------------------------------------------------------------
module refcounted_key_slot_allocator_tb;
    import rksa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 9;
    localparam int N_KEYS           = DEF_KEY_ENTRIES;
    localparam int N_SLOTS          = DEF_SLOT_COUNT;
    localparam int IDLE_PCT         = 8;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int RAND_PHASES      = 9;

    // op code three is decoded as a query; index three maps to no register
    localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [KEY_W-1:0] KEY_A = 32'hA5A5_5A5A;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot;
        logic               full;
    } answer_t;

    // ------------------------------------------------------------------------
    // DUT hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]    cfg_data    = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation = OP_QUERY;
    logic [KEY_W-1:0]         s_group_key = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic [COUNT_W-1:0]       m_member_count;
    logic signed [SLOT_W-1:0] m_slot_index;
    logic                     m_table_full;

    refcounted_key_slot_allocator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_group_key    (s_group_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_member_count (m_member_count),
        .m_slot_index   (m_slot_index),
        .m_table_full   (m_table_full)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    request_t pending_requests [$];   // items waiting for the driver
    answer_t  expected_answers [$];   // predictions waiting for their result
    int       mismatch_count = 0;
    int       idle_pct       = IDLE_PCT;  // 0 gives a stretch with no idling
    bit       long_hold      = 1'b0;      // asks the receiver for a long stall
    int       hold_left      = 0;

    // Local copy of the allocator: registers, key table, free stack.
    // Entries are only read while valid, stack words only below the depth.
    bit                  en_reg    = 1'b0;
    bit [FIRST_W-1:0]    first_reg = '0;
    bit [LIMIT_W-1:0]    limit_reg = '0;
    bit                  tbl_valid [N_KEYS];
    bit [KEY_W-1:0]      tbl_key   [N_KEYS];
    bit [COUNT_W-1:0]    tbl_count [N_KEYS];
    bit [SLOT_W-1:0]     tbl_slot  [N_KEYS];
    bit [SLOT_W-1:0]     free_slots [N_SLOTS];
    int                  free_depth = 0;

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < N_KEYS; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // a push onto a full stack is silently lost
    function automatic void push_free(logic [SLOT_W-1:0] slot);
        if (free_depth < N_SLOTS) begin
            free_slots[free_depth] = slot;
            free_depth++;
        end
    endfunction

    // empty the stack, then push first .. min(limit, N_SLOTS)-1 in rising order
    function automatic void reload_free();
        int top;
        top = (limit_reg > N_SLOTS) ? N_SLOTS : int'(limit_reg);
        free_depth = 0;
        for (int s = first_reg; s < top; s++)
            push_free(SLOT_W'(s));
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        unique case (idx)
            REG_ENABLED: begin
                en_reg = data[0];
            end
            REG_AREA_FIRST: begin
                first_reg = data[FIRST_W-1:0];
                reload_free();
            end
            REG_AREA_LIMIT: begin
                limit_reg = data[LIMIT_W-1:0];
                reload_free();
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the local table by one item and return the answer it gives.
    function automatic answer_t apply_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        answer_t ans;
        int      hit;
        int      spare;
        ans.full = 1'b0;
        hit = find_key(key);
        if (en_reg && op == OP_JOIN) begin
            if (hit >= 0) begin
                if (tbl_count[hit] != COUNT_MAX)
                    tbl_count[hit]++;
            end else begin
                spare = -1;
                for (int i = N_KEYS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        spare = i;
                if (spare < 0) begin
                    ans.full = 1'b1;       // new key, no entry left: dropped
                end else begin
                    tbl_valid[spare] = 1'b1;
                    tbl_key[spare]   = key;
                    tbl_count[spare] = 1;
                    if (free_depth > 0) begin
                        free_depth--;
                        tbl_slot[spare] = free_slots[free_depth];
                    end else begin
                        tbl_slot[spare] = NO_SLOT;
                    end
                end
            end
        end else if (en_reg && op == OP_LEAVE && hit >= 0) begin
            tbl_count[hit] = tbl_count[hit] - 1'b1;
            if (tbl_count[hit] == 0) begin
                tbl_valid[hit] = 1'b0;
                if (tbl_slot[hit] != NO_SLOT)
                    push_free(tbl_slot[hit]);
            end
        end
        hit = find_key(key);
        if (hit >= 0) begin
            ans.count = tbl_count[hit];
            ans.slot  = tbl_slot[hit];
        end else begin
            ans.count = '0;
            ans.slot  = NO_SLOT;
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next pending item once the current one is taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_requests.pop_front();
                s_valid     <= 1'b1;
                s_operation <= nxt.op;
                s_group_key <= nxt.key;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (long_hold) begin
            long_hold <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then register writes and new items, so a
    // result landing on the same edge as an accept meets the older prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: exp no result, got count %0d slot %0d full %0d",
                             $time, m_member_count, m_slot_index, m_table_full);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_member_count !== want.count || m_slot_index !== want.slot ||
                        m_table_full !== want.full) begin
                        mismatch_count++;
                        $display("%0t: count/slot/full exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.count, $signed(want.slot), want.full,
                                 m_member_count, m_slot_index, m_table_full);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (s_valid && s_ready)
                expected_answers.push_back(apply_item(s_operation, s_group_key));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. The sequence waits on falling edges and drives register
    // writes with nonblocking assignments, so it never races the clocked blocks above.
    // ------------------------------------------------------------------------
    task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        request_t r;
        r.op  = op;
        r.key = key;
        pending_requests.push_back(r);
    endtask

    // Wait until every item is answered, then give the block its latency.
    task automatic settle();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || expected_answers.size() != 0 || s_valid);
        repeat (N_KEYS + 3) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Leave every live key down to zero; only called when idle.
    task automatic drain_table();
        for (int i = 0; i < N_KEYS; i++)
            if (tbl_valid[i])
                for (int n = 0; n < tbl_count[i]; n++)
                    queue_request(OP_LEAVE, tbl_key[i]);
    endtask

    // Keys come from a small pool so joins and leaves hit live entries; the
    // pool holds both all-zero and all-one keys, plus neighbors one bit apart.
    // One item in twenty uses a fresh random key.
    task automatic random_phase(int n_items, int pool_size, int join_pct, int leave_pct);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] key;
        logic [OP_W-1:0]  op;
        int               roll;
        for (int i = 0; i < pool_size; i++) begin
            if (i == 0)
                pool.push_back('0);
            else if (i == 1)
                pool.push_back('1);
            else if ($urandom_range(1) == 0)
                pool.push_back(pool[i-1] ^ (32'd1 << $urandom_range(31)));
            else
                pool.push_back($urandom());
        end
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < join_pct)
                op = OP_JOIN;
            else if (roll < join_pct + leave_pct)
                op = OP_LEAVE;
            else if (roll < 95)
                op = OP_QUERY;
            else
                op = OP_SPARE;
            if ($urandom_range(19) == 0)
                key = $urandom();
            else
                key = pool[$urandom_range(pool.size() - 1)];
            queue_request(op, key);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic                 en_val;
        logic [FIRST_W-1:0]   first_val;
        logic [LIMIT_W-1:0]   limit_val;
        int                   n_items;
        int                   pool_n;
        int                   join_pct;
        int                   leave_pct;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Disabled out of reset: join and leave answer like a query.
        queue_request(OP_JOIN, '0);
        queue_request(OP_LEAVE, '1);
        settle();
        write_reg(REG_ENABLED, '1);      // upper data bits are don't-care
        write_reg(REG_SPARE, '1);        // no register behind this index

        // Stack still empty: the first join binds no slot.
        queue_request(OP_JOIN, KEY_A);
        queue_request(OP_JOIN, KEY_A);
        queue_request(OP_SPARE, KEY_A);  // odd op code reads back like a query
        queue_request(OP_QUERY, KEY_A ^ 32'd1);
        queue_request(OP_LEAVE, KEY_A);
        queue_request(OP_LEAVE, KEY_A);  // count hits zero, nothing to push
        queue_request(OP_LEAVE, KEY_A);  // key now unknown
        settle();

        // First takes only 8 bits (254); limit 511 clamps to the slot count.
        write_reg(REG_AREA_FIRST, 9'h1FE);
        write_reg(REG_AREA_LIMIT, '1);
        queue_request(OP_JOIN, '0);       // slot 255
        queue_request(OP_JOIN, '1);       // slot 254
        queue_request(OP_JOIN, 32'd1);    // stack exhausted
        queue_request(OP_LEAVE, '0);      // 255 goes back on top
        queue_request(OP_JOIN, 32'd2);    // reuses 255
        settle();

        // Empty range leaves the stack empty.
        write_reg(REG_AREA_FIRST, 9'd9);
        write_reg(REG_AREA_LIMIT, 9'd9);
        queue_request(OP_JOIN, 32'd3);
        settle();

        // Full stack while 254 is still bound: its release is dropped.
        write_reg(REG_AREA_FIRST, 9'd0);
        write_reg(REG_AREA_LIMIT, 9'd256);
        queue_request(OP_LEAVE, '1);
        queue_request(OP_JOIN, 32'd4);
        settle();

        // Reload while slot 1 is bound: slot 1 ends up handed out twice.
        write_reg(REG_AREA_LIMIT, 9'd2);
        queue_request(OP_JOIN, 32'd5);
        settle();
        write_reg(REG_AREA_LIMIT, 9'd2);
        queue_request(OP_JOIN, 32'd6);
        queue_request(OP_LEAVE, 32'd5);
        queue_request(OP_JOIN, 32'd7);
        settle();

        // Disabled with a live entry: nothing moves.
        write_reg(REG_ENABLED, '0);
        queue_request(OP_JOIN, 32'd7);
        queue_request(OP_LEAVE, 32'd7);
        settle();
        write_reg(REG_ENABLED, 9'h001);
        drain_table();

        // Random phases. Fixed phases cover the range extremes, the table
        // filling up, a disabled stretch and a single-slot range.
        for (int p = 0; p < RAND_PHASES; p++) begin
            en_val    = 1'b1;
            n_items   = 220;
            pool_n    = $urandom_range(2, 20);
            join_pct  = $urandom_range(35, 55);
            leave_pct = $urandom_range(25, 40);
            first_val = FIRST_W'($urandom_range(255));
            limit_val = LIMIT_W'($urandom_range(511));
            unique case (p)
                0: begin
                    first_val = 8'd0;
                    limit_val = 9'd256;
                    pool_n    = 12;
                end
                1: begin
                    // join-heavy over more keys than entries: table fills
                    first_val = 8'd0;
                    limit_val = 9'd511;
                    pool_n    = 80;
                    n_items   = 300;
                    join_pct  = 70;
                    leave_pct = 10;
                end
                2: begin
                    first_val = 8'd200;
                    limit_val = 9'd204;
                    pool_n    = 10;
                end
                3: begin
                    en_val  = 1'b0;
                    n_items = 60;
                    pool_n  = 8;
                end
                4: begin
                    first_val = 8'd255;
                    limit_val = 9'd256;
                    pool_n    = 6;
                end
                5: begin
                    first_val = 8'd255;
                    limit_val = 9'd0;
                end
                default: begin
                end
            endcase

            settle();
            write_reg(REG_ENABLED, {(CFG_DATA_W-1)'($urandom_range(255)), en_val});
            write_reg(REG_AREA_FIRST, {1'($urandom_range(1)), first_val});
            write_reg(REG_AREA_LIMIT, limit_val);

            idle_pct = (p == 1) ? 0 : IDLE_PCT;
            if (p == 0)
                long_hold = 1'b1;    // sender keeps offering while results back up
            random_phase(n_items, pool_n, join_pct, leave_pct);
            if (p == 1) begin
                settle();
                drain_table();
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("refcounted_key_slot_allocator_tb: clean");
        else
            $display("refcounted_key_slot_allocator_tb: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("refcounted_key_slot_allocator_tb: errors");
        $finish;
    end

endmodule
